[rtl/core/cds_pkg.sv]
// ----------------------------------------------------------------------------
// cds_pkg: shared types and helpers of the critically damped smoother
// Sequencer states, serial unit request/response and saturation helpers.
// ----------------------------------------------------------------------------
package cds_pkg;

    localparam int FRACTION_BITS_DEF = 16;
    localparam int WORD_W            = 64;
    localparam int SERIAL_STEPS      = 64;
    localparam int STEP_CNT_W        = $clog2(SERIAL_STEPS + 1);
    localparam int CFG_INDEX_W       = 1;
    localparam int CFG_DATA_W        = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_TIME = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_CAP   = 1'b1;

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } cds_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_OMEGA,
        S_X,
        S_X2,
        S_X3,
        S_T1,
        S_T2,
        S_DECAY,
        S_MAXC,
        S_P1,
        S_TEMP,
        S_P2,
        S_NVEL,
        S_P3,
        S_OUT
    } cds_state_t;

    // request to the serial unit; for a divide a is the divisor, b the dividend
    typedef struct packed {
        logic              start;
        cds_op_t           op;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } cds_req_t;

    // response: full product, or quotient in the low half
    typedef struct packed {
        logic                done;
        logic [2*WORD_W-1:0] prod;
    } cds_rsp_t;

    localparam logic signed [WORD_W-1:0] WIDE_LIM = 64'sd1 <<< 62;

    function automatic logic signed [WORD_W-1:0] sat_wide(input logic signed [WORD_W-1:0] v);
        logic signed [WORD_W-1:0] r;
        r = v;
        if (v > WIDE_LIM)
        begin
            r = WIDE_LIM;
        end
        else if (v < -WIDE_LIM)
        begin
            r = -WIDE_LIM;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [WORD_W-1:0] v);
        logic signed [31:0] r;
        r = v[31:0];
        if (v > 64'sd2147483647)
        begin
            r = 32'sh7fffffff;
        end
        else if (v < -64'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        return r;
    endfunction

endpackage

[rtl/core/cds_in_if.sv]
// ----------------------------------------------------------------------------
// cds_in_if: input request channel
// Valid/ready channel carrying goal and elapsed time.
// ----------------------------------------------------------------------------
interface cds_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] goal;
    logic [23:0]        elapsed;

    modport source (output valid, output goal, output elapsed, input ready);
    modport sink   (input valid, input goal, input elapsed, output ready);
endinterface

[rtl/core/cds_out_if.sv]
// ----------------------------------------------------------------------------
// cds_out_if: result request channel
// Valid/ready channel carrying position, speed and the snap flag.
// ----------------------------------------------------------------------------
interface cds_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] position;
    logic signed [31:0] speed;
    logic               snapped;

    modport source (output valid, output position, output speed, output snapped, input ready);
    modport sink   (input valid, input position, input speed, input snapped, output ready);
endinterface

[rtl/core/cds_serial_unit.sv]
// ----------------------------------------------------------------------------
// cds_serial_unit: bit-serial multiplier and restoring divider
// One operand bit per cycle, 64 steps per operation, shared registers.
// ----------------------------------------------------------------------------
module cds_serial_unit
    import cds_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cds_req_t req,
    output cds_rsp_t rsp
);

    logic [WORD_W-1:0]     hi_reg, hi_next;
    logic [WORD_W-1:0]     lo_reg, lo_next;
    logic [WORD_W-1:0]     a_reg, a_next;
    cds_op_t               op_reg, op_next;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [WORD_W:0]       sum;
    logic [WORD_W:0]       addend;
    logic [WORD_W:0]       rem;
    logic [WORD_W+1:0]     diff;
    logic                  ge;

    always_comb
    begin
        sum    = {1'b0, hi_reg} + {1'b0, a_reg};
        addend = lo_reg[0] ? sum : {1'b0, hi_reg};
        rem    = {hi_reg, lo_reg[WORD_W-1]};
        diff   = {1'b0, rem} - {2'b00, a_reg};
        ge     = !diff[WORD_W+1];

        hi_next   = hi_reg;
        lo_next   = lo_reg;
        a_next    = a_reg;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (req.start && !busy_reg)
        begin
            hi_next   = '0;
            lo_next   = req.b;
            a_next    = req.a;
            op_next   = req.op;
            cnt_next  = STEP_CNT_W'(SERIAL_STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            case (op_reg)
                OP_MUL:
                begin
                    // add multiplicand on a set bit, shift the pair right
                    hi_next = addend[WORD_W:1];
                    lo_next = {addend[0], lo_reg[WORD_W-1:1]};
                end
                OP_DIV:
                begin
                    // shift dividend bit into remainder, subtract when it fits
                    hi_next = ge ? diff[WORD_W-1:0] : rem[WORD_W-1:0];
                    lo_next = {lo_reg[WORD_W-2:0], ge};
                end
                default:
                begin
                    hi_next = hi_reg;
                end
            endcase
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= OP_MUL;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg <= hi_next;
        lo_reg <= lo_next;
        a_reg  <= a_next;
    end

    assign rsp.done = done_reg;
    assign rsp.prod = {hi_reg, lo_reg};

endmodule

[rtl/core/critically_damped_smoother_top.sv]
// ----------------------------------------------------------------------------
// critically_damped_smoother_top: critically damped spring smoother
// Sequencer around one shared bit-serial multiply/divide unit.
// ----------------------------------------------------------------------------
// Each input request (goal, elapsed) moves the kept position and velocity one
// critically damped spring step toward goal and returns one result request
// (position, speed, snapped). The work runs as 13 serial operations (two
// divides, eleven multiplies) on one bit-serial unit that retires one operand
// bit per cycle; a new request is taken as soon as the previous result has
// been loaded into the output register. The settle time and speed cap
// registers are to be written through the plain write port only while idle;
// the user must keep to this, as the block itself does not enforce it. Values
// are Q(FRACTION_BITS) fixed point and all results saturate.
// ----------------------------------------------------------------------------
module critically_damped_smoother_top
    import cds_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    cds_in_if.sink                 in_ch,
    cds_out_if.source              out_ch,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // fixed-point constants at the chosen fraction width
    localparam logic [WORD_W-1:0] ONE     = 64'd1 << FRACTION_BITS;
    localparam logic [WORD_W-1:0] ONE_2F  = 64'd1 << (2 * FRACTION_BITS);
    localparam logic [WORD_W-1:0] TWO_2F  = 64'd2 << (2 * FRACTION_BITS);
    localparam logic [WORD_W-1:0] X_CAP   = 64'd4096 << FRACTION_BITS;
    localparam logic [WORD_W-1:0] C_048   = (64'd48 * ONE + 64'd50) / 64'd100;
    localparam logic [WORD_W-1:0] C_0235  = (64'd235 * ONE + 64'd500) / 64'd1000;
    localparam logic [WORD_W-1:0] MAG_LIM = 64'd1 << 62;
    localparam logic [23:0]       MIN_SMOOTH = 24'd7;

    // configuration registers
    logic [23:0]              settle_time_reg;
    logic [31:0]              speed_cap_reg;

    // kept state
    logic signed [31:0]       cur_pos_reg, cur_pos_next;
    logic signed [31:0]       cur_vel_reg, cur_vel_next;

    // sequencer
    cds_state_t               state_reg, state_next;
    logic                     phase_reg, phase_next;
    logic                     neg_reg, neg_next;

    // per-request working registers
    logic signed [31:0]       goal_reg, goal_next;
    logic [23:0]              dt_reg, dt_next;
    logic [WORD_W-1:0]        omega_reg, omega_next;
    logic [WORD_W-1:0]        x_reg, x_next;
    logic [WORD_W-1:0]        x2_reg, x2_next;
    logic [WORD_W-1:0]        x3_reg, x3_next;
    logic [WORD_W-1:0]        den_reg, den_next;
    logic [WORD_W-1:0]        decay_reg, decay_next;
    logic signed [WORD_W-1:0] change_reg, change_next;
    logic signed [WORD_W-1:0] acc_reg, acc_next;
    logic signed [WORD_W-1:0] temp_reg, temp_next;
    logic signed [WORD_W-1:0] a3_reg, a3_next;
    logic signed [WORD_W-1:0] nvel_reg, nvel_next;
    logic signed [WORD_W-1:0] pos_reg, pos_next;

    // output register
    logic                     out_valid_reg, out_valid_next;
    logic signed [31:0]       out_pos_reg, out_pos_next;
    logic signed [31:0]       out_spd_reg, out_spd_next;
    logic                     out_snap_reg, out_snap_next;

    cds_req_t                 req;
    cds_rsp_t                 rsp;

    logic [23:0]              st;
    logic signed [WORD_W-1:0] sop;
    logic [WORD_W-1:0]        sop_mag;
    logic [2*WORD_W-1:0]      prod_sh;
    logic [WORD_W-1:0]        u_res;
    logic [WORD_W-1:0]        mag_res;
    logic signed [WORD_W-1:0] s_res;
    logic signed [WORD_W-1:0] maxc_s;
    logic signed [WORD_W-1:0] goal_w;
    logic signed [WORD_W-1:0] cur_w;
    logic signed [WORD_W-1:0] vel_w;
    logic signed [WORD_W-1:0] tgt;
    logic                     snap;
    logic                     in_accept;
    logic                     out_load;

    cds_serial_unit u_serial
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_time_reg <= 24'd16384;
            speed_cap_reg   <= 32'hffffffff;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SETTLE_TIME: settle_time_reg <= cfg_data[23:0];
                REG_SPEED_CAP:   speed_cap_reg   <= cfg_data;
                default:         speed_cap_reg   <= speed_cap_reg;
            endcase
        end
    end

    always_comb
    begin
        // tiny smooth times are raised to the minimum
        st     = (settle_time_reg < MIN_SMOOTH) ? MIN_SMOOTH : settle_time_reg;
        goal_w = WORD_W'(goal_reg);
        cur_w  = WORD_W'(cur_pos_reg);
        vel_w  = WORD_W'(cur_vel_reg);
        tgt    = cur_w - change_reg;

        // operand selection for the current serial operation
        req.op = OP_MUL;
        req.a  = '0;
        req.b  = '0;
        sop    = '0;
        case (state_reg)
            S_OMEGA:
            begin
                req.op = OP_DIV;
                req.a  = WORD_W'(st);
                req.b  = TWO_2F;
            end
            S_X:     begin req.a = omega_reg; req.b = WORD_W'(dt_reg); end
            S_X2:    begin req.a = x_reg;     req.b = x_reg;           end
            S_X3:    begin req.a = x2_reg;    req.b = x_reg;           end
            S_T1:    begin req.a = C_048;     req.b = x2_reg;          end
            S_T2:    begin req.a = C_0235;    req.b = x3_reg;          end
            S_DECAY:
            begin
                req.op = OP_DIV;
                req.a  = den_reg;
                req.b  = ONE_2F;
            end
            S_MAXC:  begin req.a = WORD_W'(speed_cap_reg); req.b = WORD_W'(st); end
            S_P1:    begin sop = change_reg; req.b = omega_reg;        end
            S_TEMP:  begin sop = acc_reg;    req.b = WORD_W'(dt_reg);  end
            S_P2:    begin sop = temp_reg;   req.b = omega_reg;        end
            S_NVEL:  begin sop = acc_reg;    req.b = decay_reg;        end
            S_P3:    begin sop = a3_reg;     req.b = decay_reg;        end
            default: req.op = OP_MUL;
        endcase
        sop_mag = (sop < 0) ? WORD_W'(-sop) : WORD_W'(sop);
        if (state_reg == S_P1 || state_reg == S_TEMP || state_reg == S_P2 ||
            state_reg == S_NVEL || state_reg == S_P3)
        begin
            req.a = sop_mag;
        end
        req.start = (state_reg != S_IDLE) && (state_reg != S_OUT) && !phase_reg;

        // scale product down, saturate unsigned, then clamp signed magnitude
        prod_sh = rsp.prod >> FRACTION_BITS;
        u_res   = (|prod_sh[2*WORD_W-1:WORD_W]) ? '1 : prod_sh[WORD_W-1:0];
        mag_res = (u_res > MAG_LIM) ? MAG_LIM : u_res;
        s_res   = neg_reg ? -$signed(mag_res) : $signed(mag_res);
        maxc_s  = $signed(u_res);

        // overshoot guard
        snap = ((goal_w > cur_w) == (pos_reg > goal_w));

        in_accept = in_ch.valid && (state_reg == S_IDLE);
        out_load  = (state_reg == S_OUT) && (!out_valid_reg || out_ch.ready);

        state_next   = state_reg;
        phase_next   = phase_reg;
        neg_next     = neg_reg;
        goal_next    = goal_reg;
        dt_next      = dt_reg;
        omega_next   = omega_reg;
        x_next       = x_reg;
        x2_next      = x2_reg;
        x3_next      = x3_reg;
        den_next     = den_reg;
        decay_next   = decay_reg;
        change_next  = change_reg;
        acc_next     = acc_reg;
        temp_next    = temp_reg;
        a3_next      = a3_reg;
        nvel_next    = nvel_reg;
        pos_next     = pos_reg;
        cur_pos_next = cur_pos_reg;
        cur_vel_next = cur_vel_reg;
        out_pos_next = out_pos_reg;
        out_spd_next = out_spd_reg;
        out_snap_next  = out_snap_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;

        if (req.start)
        begin
            phase_next = 1'b1;
            neg_next   = (sop < 0);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    goal_next   = in_ch.goal;
                    dt_next     = in_ch.elapsed;
                    change_next = cur_w - WORD_W'(in_ch.goal);
                    state_next  = S_OMEGA;
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_snap_next  = snap;
                    cur_pos_next   = snap ? goal_reg : sat32(pos_reg);
                    cur_vel_next   = snap ? 32'sd0 : sat32(nvel_reg);
                    out_pos_next   = cur_pos_next;
                    out_spd_next   = cur_vel_next;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                if (rsp.done)
                begin
                    phase_next = 1'b0;
                    case (state_reg)
                        S_OMEGA:
                        begin
                            omega_next = rsp.prod[WORD_W-1:0];
                            state_next = S_X;
                        end
                        S_X:
                        begin
                            x_next     = (u_res > X_CAP) ? X_CAP : u_res;
                            state_next = S_X2;
                        end
                        S_X2:    begin x2_next = u_res; state_next = S_X3; end
                        S_X3:    begin x3_next = u_res; state_next = S_T1; end
                        S_T1:
                        begin
                            den_next   = ONE + x_reg + u_res;
                            state_next = S_T2;
                        end
                        S_T2:
                        begin
                            den_next   = den_reg + u_res;
                            state_next = S_DECAY;
                        end
                        S_DECAY:
                        begin
                            decay_next = rsp.prod[WORD_W-1:0];
                            state_next = S_MAXC;
                        end
                        S_MAXC:
                        begin
                            // limit distance to speed cap times settle time
                            if (change_reg > maxc_s)
                            begin
                                change_next = maxc_s;
                            end
                            else if (change_reg < -maxc_s)
                            begin
                                change_next = -maxc_s;
                            end
                            state_next = S_P1;
                        end
                        S_P1:
                        begin
                            acc_next   = sat_wide(vel_w + s_res);
                            state_next = S_TEMP;
                        end
                        S_TEMP:
                        begin
                            temp_next  = s_res;
                            a3_next    = sat_wide(change_reg + s_res);
                            state_next = S_P2;
                        end
                        S_P2:
                        begin
                            acc_next   = sat_wide(vel_w - s_res);
                            state_next = S_NVEL;
                        end
                        S_NVEL:
                        begin
                            nvel_next  = s_res;
                            state_next = S_P3;
                        end
                        S_P3:
                        begin
                            pos_next   = sat_wide(tgt + s_res);
                            state_next = S_OUT;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            cur_pos_reg   <= '0;
            cur_vel_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            cur_pos_reg   <= cur_pos_next;
            cur_vel_reg   <= cur_vel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg      <= neg_next;
        goal_reg     <= goal_next;
        dt_reg       <= dt_next;
        omega_reg    <= omega_next;
        x_reg        <= x_next;
        x2_reg       <= x2_next;
        x3_reg       <= x3_next;
        den_reg      <= den_next;
        decay_reg    <= decay_next;
        change_reg   <= change_next;
        acc_reg      <= acc_next;
        temp_reg     <= temp_next;
        a3_reg       <= a3_next;
        nvel_reg     <= nvel_next;
        pos_reg      <= pos_next;
        out_pos_reg  <= out_pos_next;
        out_spd_reg  <= out_spd_next;
        out_snap_reg <= out_snap_next;
    end

    assign in_ch.ready     = (state_reg == S_IDLE);
    assign out_ch.valid    = out_valid_reg;
    assign out_ch.position = out_pos_reg;
    assign out_ch.speed    = out_spd_reg;
    assign out_ch.snapped  = out_snap_reg;

endmodule
